// File: rtl/qte_pkg.sv
// shared widths and register codes for the quintic trajectory evaluator
// no dependencies
package qte_pkg;
    localparam int POS_W = 32;
    localparam int TIME_W = 24;
    localparam int Q_W = 32;
    localparam int ADDR_W = 4;
    localparam logic [1:0] REG_START = 2'd0;
    localparam logic [1:0] REG_END = 2'd1;
    localparam logic [1:0] REG_DUR = 2'd2;
endpackage

// File: rtl/qte_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on qte_pkg
module qte_div #(
    parameter int NUM_W = 56,
    parameter int DEN_W = 24,
    parameter int TAG_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [DEN_W-1:0]   i_den,
    input  logic [TAG_W-1:0]   i_tag,
    output logic               o_valid,
    output logic [NUM_W-1:0]   o_quo,
    output logic [TAG_W-1:0]   o_tag
);
    import qte_pkg::*;

    logic [NUM_W:0]     r_vld;
    logic [DEN_W:0]     r_rem [NUM_W+1];
    logic [NUM_W-1:0]   r_num [NUM_W+1];
    logic [DEN_W-1:0]   r_den [NUM_W+1];
    logic [TAG_W-1:0]   r_tag [NUM_W+1];

    // stage zero captures the operands
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= i_valid;
        end
        r_rem[0] <= '0;
        r_num[0] <= i_num;
        r_den[0] <= i_den;
        r_tag[0] <= i_tag;
    end

    // one shift and trial subtract per stage, quotient bits shift into num
    for (genvar k = 0; k < NUM_W; k++) begin : g_st
        logic [DEN_W+1:0] w_sh;
        logic [DEN_W+1:0] w_df;
        assign w_sh = {r_rem[k], r_num[k][NUM_W-1]};
        assign w_df = w_sh - {2'b00, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_rem[k+1] <= w_df[DEN_W+1] ? w_sh[DEN_W:0] : w_df[DEN_W:0];
            r_num[k+1] <= {r_num[k][NUM_W-2:0], ~w_df[DEN_W+1]};
            r_den[k+1] <= r_den[k];
            r_tag[k+1] <= r_tag[k];
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo = r_num[NUM_W];
    assign o_tag = r_tag[NUM_W];
endmodule

// File: rtl/quintic_trajectory_eval.sv
// top level of the quintic trajectory evaluator: apb registers and pipeline
// depends on qte_pkg and qte_div
//
// usage: program start_position (0x0), end_position (0x4) and duration_ticks
// (0x8) over apb while idle, then pulse i_start with i_time_ticks. busy stays
// low, so a word may enter on every clock. each word yields one result on
// o_position and o_velocity, marked by a one-cycle o_valid strobe.
// from the accept edge to the strobe a word passes through the time/duration
// divide, the power and polynomial chain (one 32x32 product per stage), the
// distance products, the velocity divide by the duration and then sign and
// saturation, in that order.
// throughput is one word per cycle. synchronous reset clears all valid
// bits and returns registers to start 0, end 0, duration 1; words in
// flight are dropped. the receiver cannot stall, results are never held.
// time past the duration is clamped, holding the end position at zero speed.
module quintic_trajectory_eval (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [qte_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [qte_pkg::TIME_W-1:0]   i_time_ticks,
    output logic                         o_valid,
    output logic signed [qte_pkg::POS_W-1:0] o_position,
    output logic signed [qte_pkg::POS_W-1:0] o_velocity
);
    import qte_pkg::*;

    localparam int DEPTH = 6;

    logic signed [31:0] r_q0, r_qf;
    logic [TIME_W-1:0] r_dur;
    logic [1:0] w_ridx;

    // configuration registers
    assign pready = 1'b1;
    assign o_busy = 1'b0;
    assign w_ridx = paddr[3:2];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q0 <= '0;
            r_qf <= '0;
            r_dur <= TIME_W'(1);
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            unique case (w_ridx)
                REG_START: r_q0 <= pwdata;
                REG_END:   r_qf <= pwdata;
                REG_DUR:   r_dur <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end
    always_comb begin
        unique case (w_ridx)
            REG_START: prdata = r_q0;
            REG_END:   prdata = r_qf;
            REG_DUR:   prdata = {8'd0, r_dur};
            default:   prdata = '0;
        endcase
    end

    // front: clamp time, derive distance sign and magnitude
    logic [TIME_W-1:0] w_T, w_t;
    logic signed [32:0] w_d;
    logic [32:0] w_a;
    assign w_T = (r_dur == '0) ? TIME_W'(1) : r_dur;
    assign w_t = (i_time_ticks > w_T) ? w_T : i_time_ticks;
    assign w_d = 33'(r_qf) - 33'(r_q0);
    assign w_a = w_d[32] ? 33'(-w_d) : 33'(w_d);

    // s = t*2^31/T through the first divider; side data rides in the tag
    localparam int TAG1 = 33 + 1 + 32 + TIME_W;
    logic w_v1;
    logic [55:0] w_s_full;
    logic [TAG1-1:0] w_tag1;
    qte_div #(.NUM_W(56), .DEN_W(TIME_W), .TAG_W(TAG1)) u_div_s (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_start),
        .i_num({1'b0, w_t, 31'd0}), .i_den(w_T),
        .i_tag({w_a, w_d[32], r_q0, w_T}),
        .o_valid(w_v1), .o_quo(w_s_full), .o_tag(w_tag1)
    );

    // power chain: one q31 product per stage
    typedef struct packed {
        logic [32:0] a;
        logic        neg;
        logic [31:0] q0;
        logic [TIME_W-1:0] T;
    } t_side;

    logic [DEPTH-1:0] r_pv;
    t_side r_ps [DEPTH];
    logic [31:0] r_s [DEPTH];
    logic [31:0] r_s2, r_s3, r_s4, r_s5;
    logic [31:0] r_s2b, r_s3b, r_s2c;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= '0;
        else r_pv <= {r_pv[DEPTH-2:0], w_v1};
        r_ps[0] <= t_side'(w_tag1);
        r_s[0] <= w_s_full[31:0];
        for (int k = 1; k < DEPTH; k++) begin
            r_ps[k] <= r_ps[k-1];
            r_s[k] <= r_s[k-1];
        end
        r_s2 <= 32'((64'(r_s[0]) * 64'(r_s[0])) >> 31);
        r_s3 <= 32'((64'(r_s2) * 64'(r_s[1])) >> 31);
        r_s2b <= r_s2;
        r_s4 <= 32'((64'(r_s3) * 64'(r_s[2])) >> 31);
        r_s3b <= r_s3;
        r_s2c <= r_s2b;
        r_s5 <= 32'((64'(r_s4) * 64'(r_s[3])) >> 31);
    end

    // polynomial weights, after stage index 4
    logic [31:0] r_s4b;
    logic [32:0] r_P;
    logic [35:0] r_G;
    logic [31:0] r_s3c;
    logic [31:0] r_s2d;
    always_ff @(posedge i_clk) begin
        r_s4b <= r_s4;
        r_s3c <= r_s3b;
        r_s2d <= r_s2c;
    end
    // realign: s5 ready one stage after s4, delay s3/s2/s4 copies once more
    logic signed [36:0] w_p2, w_g2;
    assign w_p2 = 37'sd10 * $signed({5'd0, r_s3c}) - 37'sd15 * $signed({5'd0, r_s4b})
                + 37'sd6 * $signed({5'd0, r_s5});
    assign w_g2 = 37'sd30 * $signed({5'd0, r_s2d}) - 37'sd60 * $signed({5'd0, r_s3c})
                + 37'sd30 * $signed({5'd0, r_s4b});
    always_ff @(posedge i_clk) begin
        if (w_p2[36]) r_P <= '0;
        else if (w_p2 > 37'sh080000000) r_P <= 33'h100000000 >> 1;
        else r_P <= w_p2[32:0];
        r_G <= w_g2[36] ? '0 : w_g2[35:0];
    end

    // distance products, split in halves to keep multipliers near 32 bits
    localparam int PS = 5;
    logic [32:0] w_a5;
    assign w_a5 = r_ps[PS].a;
    logic [65:0] r_pl, r_ph;
    logic [68:0] r_gl, r_gh;
    t_side r_m1, r_m2;
    logic r_mv1, r_mv2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv1 <= 1'b0;
            r_mv2 <= 1'b0;
        end else begin
            r_mv1 <= r_pv[PS];
            r_mv2 <= r_mv1;
        end
        r_m1 <= r_ps[PS];
        r_m2 <= r_m1;
        r_pl <= 66'(w_a5 * r_P[16:0]);
        r_ph <= 66'(w_a5 * r_P[32:17]);
        r_gl <= 69'(w_a5 * r_G[17:0]);
        r_gh <= 69'(w_a5 * r_G[35:18]);
    end

    logic [66:0] r_pm;
    logic [51:0] r_gx;
    logic [68:0] w_gsum;
    assign w_gsum = (r_gh << 18) + r_gl;
    always_ff @(posedge i_clk) begin
        r_pm <= 67'(((67'(r_ph) << 17) + 67'(r_pl) + 67'h40000000) >> 31);
        r_gx <= 52'(w_gsum >> 19);
    end

    // velocity divide by the duration; position waits in the tag
    localparam int TAG2 = 1 + 32 + 67;
    logic w_v2;
    logic [51:0] w_vm;
    logic [TAG2-1:0] w_tag2;
    qte_div #(.NUM_W(52), .DEN_W(TIME_W), .TAG_W(TAG2)) u_div_v (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_mv2),
        .i_num(r_gx), .i_den(r_m2.T),
        .i_tag({r_m2.neg, r_m2.q0, r_pm}),
        .o_valid(w_v2), .o_quo(w_vm), .o_tag(w_tag2)
    );

    // signs and saturation
    logic w_neg;
    logic signed [68:0] w_pos;
    logic signed [33:0] w_vel;
    logic [32:0] w_vmc;
    assign w_neg = w_tag2[TAG2-1];
    assign w_pos = w_neg ? 69'(signed'(w_tag2[98:67])) - 69'(w_tag2[66:0])
                         : 69'(signed'(w_tag2[98:67])) + 69'(w_tag2[66:0]);
    assign w_vmc = (w_vm > 52'h80000000) ? 33'h100000000 >> 1 : w_vm[32:0];
    assign w_vel = w_neg ? -34'(w_vmc) : 34'(w_vmc);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= w_v2;
        if (w_pos > 69'sh7FFFFFFF) o_position <= 32'h7FFFFFFF;
        else if (w_pos < -69'sh80000000) o_position <= 32'h80000000;
        else o_position <= w_pos[31:0];
        if (w_vel > 34'sh7FFFFFFF) o_velocity <= 32'h7FFFFFFF;
        else o_velocity <= w_vel[31:0];
    end
endmodule

// File: tb/sv/testbench.sv
// self-checking testbench for the quintic trajectory evaluator
// depends on qte_pkg and the quintic_trajectory_eval rtl
`timescale 1ns / 1ps

// holds the programmed motion and the queue of predicted setpoints
class setpoint_board;
    typedef struct {
        logic signed [qte_pkg::POS_W-1:0] pos;
        logic signed [qte_pkg::POS_W-1:0] vel;
    } setpoint_t;

    logic [31:0]                 start_q;
    logic [31:0]                 end_q;
    logic [qte_pkg::TIME_W-1:0]  dur_q;
    setpoint_t                   pending_q[$];
    int                          n_errors;
    int                          n_checked;

    function new();
        start_q = '0;
        end_q = '0;
        dur_q = 1;
        n_errors = 0;
        n_checked = 0;
    endfunction

    // mirror a register write; unknown addresses are dropped
    function void write_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            qte_pkg::REG_START: start_q = val;
            qte_pkg::REG_END: end_q = val;
            qte_pkg::REG_DUR: dur_q = val[qte_pkg::TIME_W-1:0];
            default: ;
        endcase
    endfunction

    // work out the setpoint for one accepted time word
    function void note_time(logic [qte_pkg::TIME_W-1:0] t_in);
        logic [63:0] dur, t, s, s2, s3, s4, s5, mag, pm;
        logic [127:0] vm;
        longint q0, qf, span, p, g, pos, vel;
        setpoint_t sp;
        dur = (dur_q == 0) ? 64'd1 : 64'(dur_q);
        t = (64'(t_in) > dur) ? dur : 64'(t_in);
        s = (t << 31) / dur;
        s2 = (s * s) >> 31;
        s3 = (s2 * s) >> 31;
        s4 = (s3 * s) >> 31;
        s5 = (s4 * s) >> 31;
        p = 10 * longint'(s3) - 15 * longint'(s4) + 6 * longint'(s5);
        if (p < 0) p = 0;
        if (p > 64'h8000_0000) p = 64'h8000_0000;
        g = 30 * longint'(s2) - 60 * longint'(s3) + 30 * longint'(s4);
        if (g < 0) g = 0;
        q0 = longint'($signed(start_q));
        qf = longint'($signed(end_q));
        span = qf - q0;
        mag = (span < 0) ? 64'(-span) : 64'(span);
        // position rounds half away from zero
        pm = (mag * 64'(p) + 64'h4000_0000) >> 31;
        pos = (span < 0) ? q0 - longint'(pm) : q0 + longint'(pm);
        if (pos > 64'sh7FFF_FFFF) pos = 64'sh7FFF_FFFF;
        if (pos < -64'sh8000_0000) pos = -64'sh8000_0000;
        vm = ((128'(mag) * 128'(g)) >> 19) / 128'(dur);
        if (vm > 128'h8000_0000) vm = 128'h8000_0000;
        vel = (span < 0) ? -longint'(vm[63:0]) : longint'(vm[63:0]);
        if (vel > 64'sh7FFF_FFFF) vel = 64'sh7FFF_FFFF;
        sp.pos = pos[31:0];
        sp.vel = vel[31:0];
        pending_q.push_back(sp);
    endfunction

    // compare one result word with the oldest prediction
    function void check(logic signed [31:0] pos, logic signed [31:0] vel);
        setpoint_t sp;
        if (pending_q.size() == 0) begin
            $error("result with no prediction waiting: position %0d velocity %0d", pos, vel);
            n_errors++;
            return;
        end
        sp = pending_q.pop_front();
        n_checked++;
        if (pos !== sp.pos) begin
            $error("position: expected %0d, actual %0d", sp.pos, pos);
            n_errors++;
        end
        if (vel !== sp.vel) begin
            $error("velocity: expected %0d, actual %0d", sp.vel, vel);
            n_errors++;
        end
    endfunction
endclass

module testbench;
    import qte_pkg::*;

    localparam int DRAIN_CYCLES = 170;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 i_start;
    logic                 o_busy;
    logic [TIME_W-1:0]    i_time_ticks;
    logic                 o_valid;
    logic signed [POS_W-1:0] o_position;
    logic signed [POS_W-1:0] o_velocity;

    setpoint_board board;
    int cycles;
    int n_phases;

    quintic_trajectory_eval u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_start(i_start), .o_busy(o_busy), .i_time_ticks(i_time_ticks),
        .o_valid(o_valid), .o_position(o_position), .o_velocity(o_velocity)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // cycle count and timeout
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("** quintic_trajectory_eval: FAILED **");
            $finish;
        end
    end

    // accepted time words and result words
    always @(posedge i_clk) begin
        if (i_rst_n && i_start && !o_busy) board.note_time(i_time_ticks);
        if (i_rst_n && o_valid) board.check(o_position, o_velocity);
    end

    // apb write: setup then access
    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // present one time word after a random gap, return at its accept edge
    task automatic send_time(logic [TIME_W-1:0] t);
        int gap;
        bit took;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_time_ticks <= t;
        do begin
            @(negedge i_clk);
            took = !o_busy;
            @(posedge i_clk);
        end while (!took);
    endtask

    // let every word drain before touching the registers
    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_motion(logic [31:0] q0, logic [31:0] qf, logic [TIME_W-1:0] dur);
        settle();
        reg_write(REG_START, q0);
        reg_write(REG_END, qf);
        reg_write(REG_DUR, 32'(dur));
        n_phases++;
    endtask

    // directed times around the motion: ends, middle, past the end
    task automatic edge_times();
        logic [TIME_W-1:0] dur;
        dur = board.dur_q;
        send_time('0);
        send_time(dur >> 1);
        send_time(dur);
        if (dur != TIME_MAX) send_time(dur + 1'b1);
        send_time(TIME_MAX);
    endtask

    function automatic logic [TIME_W-1:0] rand_time();
        int unsigned hi;
        if ($urandom_range(0, 7) == 0) return TIME_W'($urandom);
        hi = int'(board.dur_q) + 2;
        if (hi > int'(TIME_MAX)) hi = TIME_MAX;
        return TIME_W'($urandom_range(0, hi));
    endfunction

    initial begin
        logic [31:0] q0, qf;
        logic [TIME_W-1:0] dur;
        board = new();
        cycles = 0;
        n_phases = 0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        i_start = 1'b0;
        i_time_ticks = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: no motion at all
        edge_times();
        // plain move, then the extremes both ways, over the longest duration and with saturating speed
        set_motion(32'h0000_0000, 32'h03E8_0000, 24'd100);
        edge_times();
        set_motion(32'h8000_0000, 32'h7FFF_FFFF, TIME_MAX);
        edge_times();
        send_time(24'h555555);
        set_motion(32'h7FFF_FFFF, 32'h8000_0000, 24'd1);
        edge_times();
        set_motion(32'h8000_0000, 32'h7FFF_FFFF, 24'd3);
        send_time(24'd1);
        send_time(24'd2);
        // zero duration acts as one tick; a write past the last register is ignored
        set_motion(32'hFFFF_0000, 32'h0001_0000, 24'd0);
        reg_write(2'd3, 32'hDEAD_BEEF);
        send_time(24'd0);
        send_time(24'd1);
        send_time(24'hAAAAAA);

        // random motions, mostly short durations with times around the move
        for (int ph = 0; ph < 25; ph++) begin
            q0 = $urandom;
            case ($urandom_range(0, 3))
                0: qf = $urandom;
                1: qf = q0 + 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
                2: qf = q0;
                default: qf = ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
            if ($urandom_range(0, 4) == 0) dur = TIME_W'($urandom);
            else dur = TIME_W'($urandom_range(1, 64));
            set_motion(q0, qf, dur);
            repeat (20) send_time(rand_time());
        end
        settle();

        $display("checked %0d setpoints over %0d register settings, %0d cycles",
                 board.n_checked, n_phases, cycles);
        if (board.n_errors == 0 && board.pending_q.size() == 0) begin
            $display("** quintic_trajectory_eval: PASSED **");
        end else begin
            $display("** quintic_trajectory_eval: FAILED **");
        end
        $finish;
    end
endmodule
